/* hdl/ctmq_pkg.sv */
// Shared types, codes and helpers of the CAN transmit mailbox queue.
`default_nettype none
package ctmq_pkg;

   // Field widths
   localparam int ID_IN_W     = 16;
   localparam int ID_W        = 11;
   localparam int LEN_W       = 4;
   localparam int DATA_W      = 64;
   localparam int MBOX_N      = 3;
   localparam int MBOX_W      = 2;
   localparam int STATUS_W    = 3;
   localparam int QCOUNT_W    = 9;
   localparam int TXCOUNT_W   = 32;
   localparam int ENTRY_W     = ID_W + LEN_W + DATA_W;

   // Stream widths, padded to whole bytes
   localparam int REQ_TDATA_W = 88;
   localparam int RSP_TDATA_W = 128;

   localparam int DEFAULT_QUEUE_DEPTH = 256;

   localparam logic [LEN_W-1:0] LENGTH_LIMIT = 4'd8;

   // Item kinds
   localparam logic KIND_SEND     = 1'b0;
   localparam logic KIND_COMPLETE = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK            = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID_ID    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_INVALID_FRAME = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_STARTED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_QUEUE_FULL    = 3'd4;

   // Commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic publish;
   } ctmq_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic out_free;
   } ctmq_stat_type;

   // Zero the data bytes at and above the frame length
   function automatic logic [DATA_W-1:0] trim_payload(input logic [DATA_W-1:0] data,
                                                      input logic [LEN_W-1:0] len);
      logic [DATA_W-1:0] r;
      r = data;
      for (int i = 0; i < DATA_W / 8; i++) begin
         if (LEN_W'(i) >= len) begin
            r[i*8 +: 8] = 8'h00;
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* hdl/ctmq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ctmq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hdl/ctmq_ctrl.sv */
// Sequencing state machine: accept a beat, execute it, publish the result.
`default_nettype none
module ctmq_ctrl
   import ctmq_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire ctmq_stat_type stat,
   output ctmq_cmd_type       cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Take a beat only while idle and out of reset
   assign req_tready  = (state_ff == S_IDLE) && !reset;
   assign cmd.capture = req_tvalid && req_tready;
   assign cmd.exec    = (state_ff == S_EXEC);
   assign cmd.publish = (state_ff == S_DONE) && stat.out_free;

   // Advance through accept, execute and publish
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.capture) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

/* hdl/ctmq_datapath.sv */
// Request checks, queue memory and pointers, counters and the result register.
`default_nettype none
module ctmq_datapath
   import ctmq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Configuration
   input  wire logic                   csr_valid,
   input  wire logic                   csr_wdata,
   // Input beat fields
   input  wire logic                   kind,
   input  wire logic [ID_IN_W-1:0]     frame_id,
   input  wire logic [LEN_W-1:0]       frame_length,
   input  wire logic [DATA_W-1:0]      frame_data,
   input  wire logic [MBOX_N-1:0]      mailbox_free,
   // Controller link
   input  wire ctmq_cmd_type           cmd,
   output ctmq_stat_type               stat,
   // Result channel
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   // Configuration and control state
   logic                 enabled_ff;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]     entry_count_ff, entry_count_in;
   logic [TXCOUNT_W-1:0] sent_ff, sent_in;
   logic                 rsp_valid_ff;

   // Captured beat
   logic                 kind_ff;
   logic [ID_IN_W-1:0]   id_ff;
   logic [LEN_W-1:0]     len_ff;
   logic [DATA_W-1:0]    data_ff;
   logic [MBOX_N-1:0]    free_ff;

   // Decision held from execute to publish
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic                 res_queued_ff, res_queued_in;
   logic                 res_load_ff, res_load_in;
   logic                 res_deq_ff, res_deq_in;

   // Result register
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic                 rsp_queued_ff;
   logic                 rsp_load_ff;
   logic [MBOX_W-1:0]    rsp_box_ff;
   logic [ID_W-1:0]      rsp_id_ff;
   logic [LEN_W-1:0]     rsp_len_ff;
   logic [DATA_W-1:0]    rsp_data_ff;
   logic [QCOUNT_W-1:0]  rsp_qcount_ff;
   logic [TXCOUNT_W-1:0] rsp_txcount_ff;

   logic                 id_bad, len_bad, box_any, q_full, q_empty;
   logic                 do_enq, do_deq;
   logic [MBOX_W-1:0]    box_sel;
   logic [DATA_W-1:0]    trimmed;
   logic [ENTRY_W-1:0]   ram_rd_data;
   logic [QCOUNT_W-1:0]  qcount;
   logic [ID_W-1:0]      ld_id;
   logic [LEN_W-1:0]     ld_len;
   logic [DATA_W-1:0]    ld_data;

   // Hold the enable register
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
      end else if (csr_valid) begin
         enabled_ff <= csr_wdata;
      end
   end

   // Capture the accepted beat
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= kind;
         id_ff   <= frame_id;
         len_ff  <= frame_length;
         data_ff <= frame_data;
         free_ff <= mailbox_free;
      end
   end

   // Classify the beat
   assign id_bad  = |id_ff[ID_IN_W-1:ID_W];
   assign len_bad = len_ff > LENGTH_LIMIT;
   assign box_any = |free_ff;
   assign box_sel = free_ff[0] ? MBOX_W'(0) : (free_ff[1] ? MBOX_W'(1) : MBOX_W'(2));
   assign q_full  = entry_count_ff == CNT_FULL;
   assign q_empty = entry_count_ff == '0;
   assign trimmed = trim_payload(data_ff, len_ff);

   always_comb begin
      res_status_in = ST_OK;
      res_queued_in = 1'b0;
      res_load_in   = 1'b0;
      res_deq_in    = 1'b0;
      if (kind_ff == KIND_SEND) begin
         if (id_bad) begin
            res_status_in = ST_INVALID_ID;
         end else if (len_bad) begin
            res_status_in = ST_INVALID_FRAME;
         end else if (!enabled_ff) begin
            res_status_in = ST_NOT_STARTED;
         end else if (box_any) begin
            res_load_in = 1'b1;
         end else if (q_full) begin
            res_status_in = ST_QUEUE_FULL;
         end else begin
            res_queued_in = 1'b1;
         end
      end else if (!q_empty && box_any) begin
         res_load_in = 1'b1;
         res_deq_in  = 1'b1;
      end
   end

   assign do_enq = cmd.exec && res_queued_in;
   assign do_deq = cmd.exec && res_deq_in;

   // Advance pointers, count and transmit counter
   always_comb begin
      rd_ptr_in      = rd_ptr_ff;
      wr_ptr_in      = wr_ptr_ff;
      entry_count_in = entry_count_ff;
      sent_in        = sent_ff;
      if (do_enq) begin
         wr_ptr_in      = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
         entry_count_in = entry_count_ff + CNT_W'(1);
      end
      if (do_deq) begin
         rd_ptr_in      = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
         entry_count_in = entry_count_ff - CNT_W'(1);
      end
      if (cmd.exec && (kind_ff == KIND_COMPLETE)) begin
         sent_in = sent_ff + TXCOUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff      <= '0;
         wr_ptr_ff      <= '0;
         entry_count_ff <= '0;
         sent_ff        <= '0;
      end else begin
         rd_ptr_ff      <= rd_ptr_in;
         wr_ptr_ff      <= wr_ptr_in;
         entry_count_ff <= entry_count_in;
         sent_ff        <= sent_in;
      end
   end

   // Hold the decision until publish
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         res_status_ff <= res_status_in;
         res_queued_ff <= res_queued_in;
         res_load_ff   <= res_load_in;
         res_deq_ff    <= res_deq_in;
      end
   end

   // Queue storage: {data, length, id}
   ctmq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (do_enq),
      .wr_addr (wr_ptr_ff),
      .wr_data ({trimmed, len_ff, id_ff[ID_W-1:0]}),
      .rd_en   (do_deq),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   // Mask the entry count to the result width
   generate
      if (CNT_W >= QCOUNT_W) begin : g_qcount_trunc
         assign qcount = entry_count_ff[QCOUNT_W-1:0];
      end else begin : g_qcount_ext
         assign qcount = {{(QCOUNT_W - CNT_W){1'b0}}, entry_count_ff};
      end
   endgenerate

   // Select the loaded frame: queue head, direct request, or none
   always_comb begin
      ld_id   = '0;
      ld_len  = '0;
      ld_data = '0;
      if (res_deq_ff) begin
         ld_id   = ram_rd_data[ID_W-1:0];
         ld_len  = ram_rd_data[ID_W +: LEN_W];
         ld_data = ram_rd_data[ID_W+LEN_W +: DATA_W];
      end else if (res_load_ff) begin
         ld_id   = id_ff[ID_W-1:0];
         ld_len  = len_ff;
         ld_data = trimmed;
      end
   end

   // Result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result register payload
   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_status_ff  <= res_status_ff;
         rsp_queued_ff  <= res_queued_ff;
         rsp_load_ff    <= res_load_ff;
         rsp_box_ff     <= res_load_ff ? box_sel : '0;
         rsp_id_ff      <= ld_id;
         rsp_len_ff     <= ld_len;
         rsp_data_ff    <= ld_data;
         rsp_qcount_ff  <= qcount;
         rsp_txcount_ff <= sent_ff;
      end
   end

   assign stat.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_tdata     = {1'b0, rsp_txcount_ff, rsp_qcount_ff, rsp_data_ff, rsp_len_ff,
                           rsp_id_ff, rsp_box_ff, rsp_load_ff, rsp_queued_ff, rsp_status_ff};

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= CNT_FULL)
      else $error("queue entry count beyond depth");

   a_enq_count: assert property (@(posedge clock) disable iff (reset)
      do_enq |=> entry_count_ff == $past(entry_count_ff) + CNT_W'(1))
      else $error("enqueue did not raise entry count");

   a_deq_count: assert property (@(posedge clock) disable iff (reset)
      do_deq |=> entry_count_ff == $past(entry_count_ff) - CNT_W'(1))
      else $error("dequeue did not lower entry count");

   a_load_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_load_ff |-> rsp_status_ff == ST_OK && !rsp_queued_ff)
      else $error("loaded frame with error status or queued flag");
`endif

endmodule
`default_nettype wire

/* hdl/can_tx_mailbox_queue.sv */
// Transmit scheduler: three mailboxes backed by a ring queue of frames.
//
// Each request beat is a send request (tuser 0) or a transmit-complete event
// (tuser 1) and yields exactly one response beat. A send request is checked
// for identifier (<= 2047), then length (<= 8), then the enable register; a
// good frame goes straight to the lowest free mailbox, else into the queue,
// else it is refused as queue full. A completion counts one transmission and
// moves the queue head into the lowest free mailbox when both exist. Data
// bytes past the length are zeroed. An item passes through accept, execute
// with one queue memory access, and publish from the registered memory read,
// plus any time the response register waits on rsp_tready; the next request
// is taken the cycle after publish. The queue memory needs no clearing after
// reset. The enable register is written over the csr channel; the user must
// write it only while the block is idle, as the block does not enforce this.
`default_nettype none
module can_tx_mailbox_queue
   import ctmq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Request stream
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // [15:0] frame_id, [19:16] frame_length, [83:20] frame_data,
   // [86:84] mailbox_free, [87] zero
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // [0] kind
   input  wire logic                   req_tuser,
   // Response stream
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [2:0] status, [3] queued, [4] load_valid, [6:5] mailbox_index,
   // [17:7] out_id, [21:18] out_length, [85:22] out_data,
   // [94:86] queue_count, [126:95] transmit_count, [127] zero
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   // Enable register write
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic                   csr_wdata
);

   ctmq_cmd_type  cmd;
   ctmq_stat_type stat;

   assign csr_ready = !reset;

   ctmq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ctmq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_wdata    (csr_wdata),
      .kind         (req_tuser),
      .frame_id     (req_tdata[15:0]),
      .frame_length (req_tdata[19:16]),
      .frame_data   (req_tdata[83:20]),
      .mailbox_free (req_tdata[86:84]),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

endmodule
`default_nettype wire
